FILE: rtl/mhtd_pkg.sv
// ----------------------------------------------------------------------------
// mhtd_pkg: shared types and constants of the message header deframer
// Parser phases, result kinds, the queued result record and field sizes.
// ----------------------------------------------------------------------------
package mhtd_pkg;

	// field sizes of the fixed header
	localparam int LEN_BYTES       = 4;
	localparam int HLEN_BYTES      = 2;
	localparam int ID_BYTES        = 4;
	localparam int MIN_HDR_LEN     = 6;   // id + flags + content type
	localparam int FIXED_AFTER_LEN = 8;   // header length field + MIN_HDR_LEN
	localparam int FCNT_W          = 2;   // counts bytes within a multi-byte field

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		PH_LEN,
		PH_HLEN,
		PH_ID,
		PH_FLAGS,
		PH_CTYPE,
		PH_OTYPE,
		PH_OLEN,
		PH_OVAL,
		PH_PAYLOAD,
		PH_DISCARD
	} phase_t;

	typedef enum logic [2:0] {
		KIND_FIXED   = 3'd0,
		KIND_OPTHDR  = 3'd1,
		KIND_OPTVAL  = 3'd2,
		KIND_PAYLOAD = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       item_kind;
		logic [31:0] total_length;
		logic [15:0] header_length;
		logic [31:0] message_id;
		logic [7:0]  flag_bits;
		logic [7:0]  content_type;
		logic [7:0]  option_type;
		logic [7:0]  option_length;
		logic [7:0]  byte_out;
		logic        last_of_message;
	} item_t;

	typedef struct packed {
		logic not_full;
		logic not_empty;
	} q_status_t;

endpackage

FILE: rtl/mhtd_ifs.sv
// ----------------------------------------------------------------------------
// mhtd_ifs: valid/ready channels of the deframer
// Byte input channel and result item output channel.
// ----------------------------------------------------------------------------
interface mhtd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface mhtd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  item_kind;
	logic [31:0] total_length;
	logic [15:0] header_length;
	logic [31:0] message_id;
	logic [7:0]  flag_bits;
	logic [7:0]  content_type;
	logic [7:0]  option_type;
	logic [7:0]  option_length;
	logic [7:0]  byte_out;
	logic        last_of_message;

	modport source(
		output valid, output item_kind, output total_length, output header_length,
		output message_id, output flag_bits, output content_type, output option_type,
		output option_length, output byte_out, output last_of_message, input ready
	);
	modport sink(
		input valid, input item_kind, input total_length, input header_length,
		input message_id, input flag_bits, input content_type, input option_type,
		input option_length, input byte_out, input last_of_message, output ready
	);
endinterface

FILE: rtl/mhtd_front.sv
// ----------------------------------------------------------------------------
// mhtd_front: byte parser
// Tracks the layout one byte per cycle while queue has room; pushes raw records.
// ----------------------------------------------------------------------------
module mhtd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	mhtd_in_if.sink               byte_stream,
	input  mhtd_pkg::q_status_t   q_status,
	output logic                  push,
	output mhtd_pkg::item_t       push_item
);

	mhtd_pkg::phase_t phase_q, phase_d;
	logic [mhtd_pkg::FCNT_W-1:0] fcnt_q, fcnt_d;
	logic [31:0] len_q, len_d;
	logic [15:0] hlen_q, hlen_d;
	logic [31:0] id_q, id_d;
	logic [7:0]  flags_q, flags_d;
	logic [7:0]  ctype_q, ctype_d;
	logic [15:0] opt_left_q, opt_left_d;
	logic [7:0]  otype_q, otype_d;
	logic [7:0]  olen_q, olen_d;
	logic [7:0]  oleft_q, oleft_d;
	logic [31:0] msg_left_q, msg_left_d;

	logic        accept;
	logic        emit;
	logic [7:0]  b;
	logic [31:0] msg_dec;
	logic        msg_dec_zero;
	logic [15:0] opt_dec;
	logic        opt_dec_nz;
	logic        hdr_err;
	logic [31:0] len_sub;
	mhtd_pkg::kind_t kind;
	logic        last;

	assign byte_stream.ready = q_status.not_full;
	assign accept = byte_stream.valid && byte_stream.ready;
	assign b      = byte_stream.data_byte;

	// saturating decrements of the two running counts
	assign msg_dec      = msg_left_q - {31'd0, (msg_left_q != 32'd0)};
	assign msg_dec_zero = (msg_left_q <= 32'd1);
	assign opt_dec      = opt_left_q - {15'd0, (opt_left_q != 16'd0)};
	assign opt_dec_nz   = (opt_left_q >= 16'd2);

	assign len_sub = len_q - 32'(mhtd_pkg::FIXED_AFTER_LEN);
	assign hdr_err = (hlen_q < 16'(mhtd_pkg::MIN_HDR_LEN)) ||
		({1'b0, len_q} < ({17'd0, hlen_q} + 33'(mhtd_pkg::HLEN_BYTES)));

	always_comb begin
		phase_d    = phase_q;
		fcnt_d     = fcnt_q;
		len_d      = len_q;
		hlen_d     = hlen_q;
		id_d       = id_q;
		flags_d    = flags_q;
		ctype_d    = ctype_q;
		opt_left_d = opt_left_q;
		otype_d    = otype_q;
		olen_d     = olen_q;
		oleft_d    = oleft_q;
		msg_left_d = msg_left_q;
		emit       = 1'b0;
		kind       = mhtd_pkg::KIND_PAYLOAD;
		last       = 1'b0;
		case (phase_q)
			mhtd_pkg::PH_LEN: begin
				len_d  = {len_q[23:0], b};
				fcnt_d = fcnt_q + 1'b1;
				if (fcnt_q == mhtd_pkg::FCNT_W'(mhtd_pkg::LEN_BYTES - 1)) begin
					fcnt_d  = '0;
					phase_d = mhtd_pkg::PH_HLEN;
				end
			end
			mhtd_pkg::PH_HLEN: begin
				hlen_d = {hlen_q[7:0], b};
				fcnt_d = fcnt_q + 1'b1;
				if (fcnt_q == mhtd_pkg::FCNT_W'(mhtd_pkg::HLEN_BYTES - 1)) begin
					fcnt_d  = '0;
					phase_d = mhtd_pkg::PH_ID;
				end
			end
			mhtd_pkg::PH_ID: begin
				id_d   = {id_q[23:0], b};
				fcnt_d = fcnt_q + 1'b1;
				if (fcnt_q == mhtd_pkg::FCNT_W'(mhtd_pkg::ID_BYTES - 1)) begin
					fcnt_d  = '0;
					phase_d = mhtd_pkg::PH_FLAGS;
				end
			end
			mhtd_pkg::PH_FLAGS: begin
				flags_d = b;
				phase_d = mhtd_pkg::PH_CTYPE;
			end
			mhtd_pkg::PH_CTYPE: begin
				ctype_d = b;
				otype_d = '0;
				olen_d  = '0;
				oleft_d = '0;
				emit    = 1'b1;
				if (hdr_err) begin
					// bad header: drop what is left of the message, if any
					opt_left_d = '0;
					msg_left_d = (len_q > 32'(mhtd_pkg::FIXED_AFTER_LEN)) ? len_sub : 32'd0;
					kind       = mhtd_pkg::KIND_ERROR;
					last       = 1'b1;
					phase_d    = (len_q > 32'(mhtd_pkg::FIXED_AFTER_LEN)) ?
						mhtd_pkg::PH_DISCARD : mhtd_pkg::PH_LEN;
				end else begin
					opt_left_d = hlen_q - 16'(mhtd_pkg::MIN_HDR_LEN);
					msg_left_d = len_sub;
					kind       = mhtd_pkg::KIND_FIXED;
					last       = (len_sub == 32'd0);
					if (len_sub == 32'd0)
						phase_d = mhtd_pkg::PH_LEN;
					else if (hlen_q != 16'(mhtd_pkg::MIN_HDR_LEN))
						phase_d = mhtd_pkg::PH_OTYPE;
					else
						phase_d = mhtd_pkg::PH_PAYLOAD;
				end
			end
			mhtd_pkg::PH_OTYPE: begin
				msg_left_d = msg_dec;
				if (!opt_dec_nz) begin
					// type byte with no room for its length byte
					opt_left_d = '0;
					emit       = 1'b1;
					kind       = mhtd_pkg::KIND_ERROR;
					last       = 1'b1;
					phase_d    = msg_dec_zero ? mhtd_pkg::PH_LEN : mhtd_pkg::PH_DISCARD;
				end else begin
					opt_left_d = opt_dec;
					otype_d    = b;
					olen_d     = '0;
					oleft_d    = '0;
					phase_d    = mhtd_pkg::PH_OLEN;
				end
			end
			mhtd_pkg::PH_OLEN: begin
				msg_left_d = msg_dec;
				emit       = 1'b1;
				if ({8'd0, b} > opt_dec) begin
					// value overruns the header area
					opt_left_d = '0;
					kind       = mhtd_pkg::KIND_ERROR;
					last       = 1'b1;
					phase_d    = msg_dec_zero ? mhtd_pkg::PH_LEN : mhtd_pkg::PH_DISCARD;
				end else begin
					opt_left_d = opt_dec;
					olen_d     = b;
					oleft_d    = b;
					kind       = mhtd_pkg::KIND_OPTHDR;
					last       = msg_dec_zero;
					if (b != 8'd0)
						phase_d = mhtd_pkg::PH_OVAL;
					else if (msg_dec_zero)
						phase_d = mhtd_pkg::PH_LEN;
					else if (opt_dec_nz)
						phase_d = mhtd_pkg::PH_OTYPE;
					else
						phase_d = mhtd_pkg::PH_PAYLOAD;
				end
			end
			mhtd_pkg::PH_OVAL: begin
				msg_left_d = msg_dec;
				opt_left_d = opt_dec;
				oleft_d    = oleft_q - {7'd0, (oleft_q != 8'd0)};
				emit       = 1'b1;
				kind       = mhtd_pkg::KIND_OPTVAL;
				last       = msg_dec_zero;
				if (oleft_q <= 8'd1) begin
					if (msg_dec_zero)
						phase_d = mhtd_pkg::PH_LEN;
					else if (opt_dec_nz)
						phase_d = mhtd_pkg::PH_OTYPE;
					else
						phase_d = mhtd_pkg::PH_PAYLOAD;
				end
			end
			mhtd_pkg::PH_PAYLOAD: begin
				msg_left_d = msg_dec;
				emit       = 1'b1;
				kind       = mhtd_pkg::KIND_PAYLOAD;
				last       = msg_dec_zero;
				if (msg_dec_zero)
					phase_d = mhtd_pkg::PH_LEN;
			end
			mhtd_pkg::PH_DISCARD: begin
				msg_left_d = msg_dec;
				if (msg_dec_zero)
					phase_d = mhtd_pkg::PH_LEN;
			end
			default: begin
				phase_d = mhtd_pkg::PH_LEN;
				fcnt_d  = '0;
			end
		endcase
	end

	// raw record; the back end clears fields that do not belong to the kind
	always_comb begin
		push_item.item_kind       = kind;
		push_item.total_length    = len_q;
		push_item.header_length   = hlen_q;
		push_item.message_id      = id_q;
		push_item.flag_bits       = flags_q;
		push_item.content_type    = (phase_q == mhtd_pkg::PH_CTYPE) ? b : ctype_q;
		push_item.option_type     = otype_q;
		push_item.option_length   = (phase_q == mhtd_pkg::PH_OLEN) ? b : olen_q;
		push_item.byte_out        = b;
		push_item.last_of_message = last;
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mhtd_pkg::PH_LEN;
			fcnt_q     <= '0;
			len_q      <= '0;
			hlen_q     <= '0;
			id_q       <= '0;
			flags_q    <= '0;
			ctype_q    <= '0;
			opt_left_q <= '0;
			otype_q    <= '0;
			olen_q     <= '0;
			oleft_q    <= '0;
			msg_left_q <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			fcnt_q     <= fcnt_d;
			len_q      <= len_d;
			hlen_q     <= hlen_d;
			id_q       <= id_d;
			flags_q    <= flags_d;
			ctype_q    <= ctype_d;
			opt_left_q <= opt_left_d;
			otype_q    <= otype_d;
			olen_q     <= olen_d;
			oleft_q    <= oleft_d;
			msg_left_q <= msg_left_d;
		end
	end

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && (push_item.item_kind == mhtd_pkg::KIND_ERROR) |-> push_item.last_of_message)
		else $error("error item without end of message");

	a_opt_within_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == mhtd_pkg::PH_OTYPE || phase_q == mhtd_pkg::PH_OLEN ||
		 phase_q == mhtd_pkg::PH_OVAL) |->
		 (msg_left_q[31:16] != 16'd0 || opt_left_q <= msg_left_q[15:0]))
		else $error("option area runs past the message");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_item.last_of_message &&
		(push_item.item_kind != mhtd_pkg::KIND_ERROR) |=> (phase_q == mhtd_pkg::PH_LEN))
		else $error("parser not back at length field after last item");

endmodule

FILE: rtl/mhtd_queue.sv
// ----------------------------------------------------------------------------
// mhtd_queue: short result queue
// Flop-based FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module mhtd_queue #(
	parameter int DEPTH = mhtd_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mhtd_pkg::item_t     push_item,
	input  logic                pop,
	output mhtd_pkg::item_t     pop_item,
	output mhtd_pkg::q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mhtd_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.not_full  = (count_q != CNT_W'(DEPTH));
	assign status.not_empty = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

FILE: rtl/mhtd_back.sv
// ----------------------------------------------------------------------------
// mhtd_back: output stage
// Pops queued records, clears fields per kind and holds the result register.
// ----------------------------------------------------------------------------
module mhtd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mhtd_pkg::q_status_t q_status,
	input  mhtd_pkg::item_t     pop_item,
	output logic                pop,
	mhtd_out_if.source          item_stream
);

	mhtd_pkg::item_t out_q, fmt;
	logic            valid_q;
	logic            opt_kind;
	logic            byte_kind;

	assign pop = q_status.not_empty && (!valid_q || item_stream.ready);

	assign opt_kind  = (pop_item.item_kind == mhtd_pkg::KIND_OPTHDR) ||
	                   (pop_item.item_kind == mhtd_pkg::KIND_OPTVAL);
	assign byte_kind = (pop_item.item_kind == mhtd_pkg::KIND_OPTVAL) ||
	                   (pop_item.item_kind == mhtd_pkg::KIND_PAYLOAD);

	always_comb begin
		fmt = pop_item;
		if (!opt_kind) begin
			fmt.option_type   = '0;
			fmt.option_length = '0;
		end
		if (!byte_kind)
			fmt.byte_out = '0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= fmt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (item_stream.ready)
			valid_q <= 1'b0;
	end

	assign item_stream.valid           = valid_q;
	assign item_stream.item_kind       = out_q.item_kind;
	assign item_stream.total_length    = out_q.total_length;
	assign item_stream.header_length   = out_q.header_length;
	assign item_stream.message_id      = out_q.message_id;
	assign item_stream.flag_bits       = out_q.flag_bits;
	assign item_stream.content_type    = out_q.content_type;
	assign item_stream.option_type     = out_q.option_type;
	assign item_stream.option_length   = out_q.option_length;
	assign item_stream.byte_out        = out_q.byte_out;
	assign item_stream.last_of_message = out_q.last_of_message;

endmodule

FILE: rtl/message_header_tlv_deframer.sv
// ----------------------------------------------------------------------------
// message_header_tlv_deframer: message stream deframer with option headers
// Splits a framed byte stream into header, option and payload result items.
// ----------------------------------------------------------------------------
// Path: a byte that produces a result enters the result queue at the edge that
//   accepts it and then moves to the output register that drives item_stream.
// Throughput: one byte per cycle; ready falls only while the result queue
//   (QUEUE_DEPTH entries) is full; the parser never holds a byte back.
// Reset: arst_n clears the parser to the first length byte, empties the queue
//   and drops the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module message_header_tlv_deframer #(
	parameter int QUEUE_DEPTH = mhtd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	mhtd_in_if.sink    byte_stream,
	mhtd_out_if.source item_stream
);

	// parser -> queue request path
	logic                push;
	mhtd_pkg::item_t     push_item;
	// queue -> output stage
	logic                pop;
	mhtd_pkg::item_t     pop_item;
	mhtd_pkg::q_status_t q_status;

	// front: one byte per cycle, stalls only on a full queue
	mhtd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_stream (byte_stream),
		.q_status    (q_status),
		.push        (push),
		.push_item   (push_item)
	);

	// decouples parser from output back-pressure
	mhtd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	// back: field cleanup and the output register
	mhtd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.pop_item    (pop_item),
		.pop         (pop),
		.item_stream (item_stream)
	);

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the message header deframer
// Frames byte streams of well-formed and broken messages, runs them through
// a cycle-free model of the parser and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_top;

	typedef logic [7:0] octet_t;
	typedef octet_t octet_q_t[$];

	// kinds of message that the random traffic mixes
	typedef enum int {
		MSG_GOOD,
		MSG_HLEN_LOW,
		MSG_LEN_SHORT,
		MSG_LONE_TYPE,
		MSG_OPT_OVERRUN
	} msg_shape_t;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PERCENT = 17;
	localparam int DRAIN_CYCLES = 4;

	logic clk;
	logic arst_n;

	mhtd_in_if  byte_if();
	mhtd_out_if item_if();

	message_header_tlv_deframer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_if),
		.item_stream(item_if)
	);

	// ------------------------------------------------------------------------
	// Parser model state: mirrors what the block must hold between bytes.
	// ------------------------------------------------------------------------
	mhtd_pkg::phase_t rx_phase;
	int          field_idx;
	logic [31:0] len_acc;
	logic [15:0] hlen_acc;
	logic [31:0] id_acc;
	logic [7:0]  flags_acc;
	logic [7:0]  ctype_acc;
	logic [15:0] area_left;      // header bytes still owed to options
	logic [7:0]  opt_type_acc;
	logic [7:0]  opt_len_acc;
	logic [7:0]  value_left;     // value bytes left in the current option
	logic [31:0] msg_left;       // bytes of the message still to come

	mhtd_pkg::item_t expected_items[$];
	mhtd_pkg::item_t oldest_item;

	int  mismatches;
	int  cycle_count;
	int  sent_bytes;
	bit  idle_on;                // random gaps on both channels
	octet_q_t none;

	// ------------------------------------------------------------------------
	// Clock, reset, watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// the watchdog owns the only exit on a hang
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------------
	function automatic void queue_item(mhtd_pkg::kind_t kind, octet_t otype, octet_t olen,
			octet_t value, logic last);
		mhtd_pkg::item_t it;
		it.item_kind       = kind;
		it.total_length    = len_acc;
		it.header_length   = hlen_acc;
		it.message_id      = id_acc;
		it.flag_bits       = flags_acc;
		it.content_type    = ctype_acc;
		it.option_type     = otype;
		it.option_length   = olen;
		it.byte_out        = value;
		it.last_of_message = last;
		expected_items.push_back(it);
	endfunction

	// after the fixed header or a finished option: more options, payload or
	// the next message
	function automatic void next_after_header();
		if (msg_left == 0)
			rx_phase = mhtd_pkg::PH_LEN;
		else if (area_left != 0)
			rx_phase = mhtd_pkg::PH_OTYPE;
		else
			rx_phase = mhtd_pkg::PH_PAYLOAD;
	endfunction

	function automatic void deframe_byte(octet_t b);
		bit bad;
		bad = 1'b0;
		case (rx_phase)
			mhtd_pkg::PH_LEN: begin
				len_acc = (field_idx == 0) ? {24'd0, b} : {len_acc[23:0], b};
				field_idx++;
				if (field_idx >= mhtd_pkg::LEN_BYTES) begin
					field_idx = 0;
					rx_phase  = mhtd_pkg::PH_HLEN;
				end
			end
			mhtd_pkg::PH_HLEN: begin
				hlen_acc = (field_idx == 0) ? {8'd0, b} : {hlen_acc[7:0], b};
				field_idx++;
				if (field_idx >= mhtd_pkg::HLEN_BYTES) begin
					field_idx = 0;
					rx_phase  = mhtd_pkg::PH_ID;
				end
			end
			mhtd_pkg::PH_ID: begin
				id_acc = (field_idx == 0) ? {24'd0, b} : {id_acc[23:0], b};
				field_idx++;
				if (field_idx >= mhtd_pkg::ID_BYTES) begin
					field_idx = 0;
					rx_phase  = mhtd_pkg::PH_FLAGS;
				end
			end
			mhtd_pkg::PH_FLAGS: begin
				flags_acc = b;
				rx_phase  = mhtd_pkg::PH_CTYPE;
			end
			mhtd_pkg::PH_CTYPE: begin
				ctype_acc    = b;
				opt_type_acc = '0;
				opt_len_acc  = '0;
				value_left   = '0;
				// 33-bit compare: header length plus 2 may pass 16 bits
				if (hlen_acc < mhtd_pkg::MIN_HDR_LEN ||
						{1'b0, len_acc} < {17'd0, hlen_acc} + 33'd2) begin
					area_left = '0;
					msg_left  = (len_acc > mhtd_pkg::FIXED_AFTER_LEN) ?
						32'(len_acc - mhtd_pkg::FIXED_AFTER_LEN) : '0;
					bad       = 1'b1;
				end else begin
					area_left = 16'(hlen_acc - mhtd_pkg::MIN_HDR_LEN);
					msg_left  = 32'(len_acc - mhtd_pkg::FIXED_AFTER_LEN);
					queue_item(mhtd_pkg::KIND_FIXED, '0, '0, '0, msg_left == 0);
					next_after_header();
				end
			end
			mhtd_pkg::PH_OTYPE: begin
				if (msg_left != 0) msg_left--;
				// a type byte needs room for its length byte too
				if (area_left < 2) begin
					area_left = '0;
					bad       = 1'b1;
				end else begin
					area_left--;
					opt_type_acc = b;
					opt_len_acc  = '0;
					value_left   = '0;
					rx_phase     = mhtd_pkg::PH_OLEN;
				end
			end
			mhtd_pkg::PH_OLEN: begin
				if (msg_left != 0) msg_left--;
				if (area_left != 0) area_left--;
				if (b > area_left) begin
					area_left = '0;
					bad       = 1'b1;
				end else begin
					opt_len_acc = b;
					value_left  = b;
					queue_item(mhtd_pkg::KIND_OPTHDR, opt_type_acc, b, '0, msg_left == 0);
					if (b != 0)
						rx_phase = mhtd_pkg::PH_OVAL;
					else
						next_after_header();
				end
			end
			mhtd_pkg::PH_OVAL: begin
				if (msg_left != 0) msg_left--;
				if (area_left != 0) area_left--;
				if (value_left != 0) value_left--;
				queue_item(mhtd_pkg::KIND_OPTVAL, opt_type_acc, opt_len_acc, b,
					msg_left == 0);
				if (value_left == 0) next_after_header();
			end
			mhtd_pkg::PH_PAYLOAD: begin
				if (msg_left != 0) msg_left--;
				queue_item(mhtd_pkg::KIND_PAYLOAD, '0, '0, b, msg_left == 0);
				if (msg_left == 0) rx_phase = mhtd_pkg::PH_LEN;
			end
			mhtd_pkg::PH_DISCARD: begin
				if (msg_left != 0) msg_left--;
				if (msg_left == 0) rx_phase = mhtd_pkg::PH_LEN;
			end
			default: begin
				rx_phase  = mhtd_pkg::PH_LEN;
				field_idx = 0;
			end
		endcase
		// an error ends the message; whatever is left is swallowed
		if (bad) begin
			queue_item(mhtd_pkg::KIND_ERROR, '0, '0, '0, 1'b1);
			rx_phase = (msg_left == 0) ? mhtd_pkg::PH_LEN : mhtd_pkg::PH_DISCARD;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Result side: random stalls on ready, in-order compare on each request
	// ------------------------------------------------------------------------
	initial begin
		item_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			item_if.ready = idle_on ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// outputs sampled at the rising edge, before the block updates them
	always @(posedge clk) begin
		if (arst_n && item_if.valid === 1'b1 && item_if.ready === 1'b1) begin
			if (expected_items.size() == 0) begin
				$error("item_kind: expected no result, got 0x%0h", item_if.item_kind);
				mismatches++;
			end else begin
				oldest_item = expected_items.pop_front();
				check_field("item_kind", oldest_item.item_kind, item_if.item_kind);
				check_field("total_length", oldest_item.total_length, item_if.total_length);
				check_field("header_length", oldest_item.header_length,
					item_if.header_length);
				check_field("message_id", oldest_item.message_id, item_if.message_id);
				check_field("flag_bits", oldest_item.flag_bits, item_if.flag_bits);
				check_field("content_type", oldest_item.content_type, item_if.content_type);
				check_field("option_type", oldest_item.option_type, item_if.option_type);
				check_field("option_length", oldest_item.option_length,
					item_if.option_length);
				check_field("byte_out", oldest_item.byte_out, item_if.byte_out);
				check_field("last_of_message", oldest_item.last_of_message,
					item_if.last_of_message);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Byte side. Every task below is entered and left at a falling edge.
	// ------------------------------------------------------------------------
	// one request: valid stays up until the edge where ready is seen high
	task automatic send_byte(octet_t b);
		while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			byte_if.valid = 1'b0;
			@(negedge clk);
		end
		byte_if.valid     = 1'b1;
		byte_if.data_byte = b;
		@(posedge clk);
		while (byte_if.ready !== 1'b1) @(posedge clk);
		deframe_byte(b);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_message(logic [31:0] len, logic [15:0] hlen, logic [31:0] mid,
			octet_t flags, octet_t ctype, octet_q_t body);
		for (int i = mhtd_pkg::LEN_BYTES - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
		for (int i = mhtd_pkg::HLEN_BYTES - 1; i >= 0; i--) send_byte(hlen[8*i +: 8]);
		for (int i = mhtd_pkg::ID_BYTES - 1; i >= 0; i--) send_byte(mid[8*i +: 8]);
		send_byte(flags);
		send_byte(ctype);
		foreach (body[i]) send_byte(body[i]);
	endtask

	// lengths follow from the option area and payload sizes
	task automatic send_framed(logic [31:0] mid, octet_t flags, octet_t ctype,
			octet_q_t area, octet_q_t payload);
		logic [15:0] hlen;
		logic [31:0] len;
		octet_q_t    body;
		hlen = 16'(area.size() + mhtd_pkg::MIN_HDR_LEN);
		len  = 32'(hlen) + 32'd2 + 32'(payload.size());
		body = {area, payload};
		send_message(len, hlen, mid, flags, ctype, body);
	endtask

	function automatic octet_q_t random_bytes(int n);
		octet_q_t q;
		repeat (n) q.push_back(octet_t'($urandom_range(0, 255)));
		return q;
	endfunction

	// pauses the sender until every result is out
	task automatic wait_drained();
		while (expected_items.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Random messages
	// ------------------------------------------------------------------------
	function automatic msg_shape_t pick_shape();
		int p;
		p = $urandom_range(0, 99);
		if (p < 72) return MSG_GOOD;
		if (p < 79) return MSG_HLEN_LOW;
		if (p < 86) return MSG_LEN_SHORT;
		if (p < 93) return MSG_LONE_TYPE;
		return MSG_OPT_OVERRUN;
	endfunction

	// well-formed options, mostly short values, now and then a longer one
	task automatic add_random_options(ref octet_q_t area);
		int n;
		int olen;
		n = $urandom_range(0, 3);
		repeat (n) begin
			olen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 4);
			area.push_back(octet_t'($urandom_range(0, 255)));
			area.push_back(octet_t'(olen));
			repeat (olen) area.push_back(octet_t'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_random_message();
		msg_shape_t  shape;
		octet_q_t    area;
		octet_q_t    payload;
		int          spare;
		int          plen;
		logic [15:0] hlen;
		logic [31:0] len;
		shape = pick_shape();
		if (shape == MSG_GOOD || shape == MSG_LONE_TYPE || shape == MSG_OPT_OVERRUN) begin
			add_random_options(area);
			if (shape == MSG_LONE_TYPE) begin
				// a type byte with no room left for its length byte
				area.push_back(octet_t'($urandom_range(0, 255)));
			end else if (shape == MSG_OPT_OVERRUN) begin
				// option length beyond the header area still open
				spare = $urandom_range(0, 3);
				area.push_back(octet_t'($urandom_range(0, 255)));
				area.push_back(octet_t'($urandom_range(spare + 1, 255)));
				repeat (spare) area.push_back(octet_t'($urandom_range(0, 255)));
			end
			plen    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
			payload = random_bytes(plen);
			send_framed($urandom, octet_t'($urandom_range(0, 255)),
				octet_t'($urandom_range(0, 255)), area, payload);
		end else begin
			if (shape == MSG_HLEN_LOW) begin
				hlen = 16'($urandom_range(0, mhtd_pkg::MIN_HDR_LEN - 1));
				len  = $urandom_range(0, 30);
			end else begin
				hlen = ($urandom_range(0, 3) == 0) ?
					16'($urandom_range(mhtd_pkg::MIN_HDR_LEN, 65535))
					: 16'($urandom_range(mhtd_pkg::MIN_HDR_LEN, 40));
				len  = $urandom_range(0, (hlen + 1 > 40) ? 40 : hlen + 1);
			end
			send_message(len, hlen, $urandom, octet_t'($urandom_range(0, 255)),
				octet_t'($urandom_range(0, 255)),
				random_bytes((len > mhtd_pkg::FIXED_AFTER_LEN) ?
					int'(len - mhtd_pkg::FIXED_AFTER_LEN) : 0));
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// header only (last on the fixed item), then a single payload byte
	task automatic test_minimal_messages();
		send_framed(32'h0000_0000, 8'h00, 8'h00, none, none);
		send_framed(32'hFFFF_FFFF, 8'hFF, 8'hFF, none, '{8'hA5});
	endtask

	// zero-length and valued options; messages ending in three kinds of item
	task automatic test_option_kinds();
		send_framed(32'h1234_5678, 8'h81, 8'h7E,
			'{8'h00, 8'h00, 8'hFF, 8'h02, 8'h00, 8'hFF}, '{8'h5A, 8'hC3});
		send_framed(32'h0F0F_0F0F, 8'h3C, 8'hC3, '{8'h11, 8'h01, 8'h7E}, none);
		send_framed(32'hF0F0_F0F0, 8'h55, 8'hAA, '{8'h22, 8'h00}, none);
	endtask

	// header length below the fixed part, and length too short for the header
	task automatic test_header_errors();
		send_message(32'd20, 16'd5, 32'hDEAD_0001, 8'h01, 8'h02, random_bytes(12));
		send_message(32'd3, 16'd0, 32'hDEAD_0002, 8'h03, 8'h04, none);
		send_message(32'd10, 16'hFFFF, 32'hDEAD_0003, 8'h05, 8'h06, random_bytes(2));
		send_message(32'd9, 16'd8, 32'hDEAD_0004, 8'h07, 8'h08, random_bytes(1));
		send_message(32'd7, 16'd6, 32'hDEAD_0005, 8'h09, 8'h0A, none);
	endtask

	// lone type byte, option length past the area, overrun at message end
	task automatic test_option_errors();
		send_framed(32'hBEEF_0001, 8'h10, 8'h20, '{8'h01, 8'h00, 8'h42},
			'{8'h61, 8'h62, 8'h63});
		send_framed(32'hBEEF_0002, 8'h30, 8'h40, '{8'h33, 8'h03, 8'h00, 8'h00},
			'{8'h71, 8'h72});
		send_framed(32'hBEEF_0003, 8'h50, 8'h60, '{8'h44, 8'h01}, none);
	endtask

	// largest option value count, each byte value from 0 to 254 once
	task automatic test_long_option();
		octet_q_t area;
		area.push_back(8'h99);
		area.push_back(8'hFF);
		for (int i = 0; i < 255; i++) area.push_back(octet_t'(i));
		send_framed(32'h0BAD_CAFE, 8'h00, 8'hFF, area, '{8'hFF});
	endtask

	// random mix; most of it runs with no gaps or stalls at all
	task automatic test_random_traffic();
		int start;
		int done;
		start = sent_bytes;
		done  = 0;
		while (done < 90) begin
			idle_on = (done < 15 || done >= 75);
			send_random_message();
			done = sent_bytes - start;
		end
		idle_on = 1'b1;
	endtask

	// sender holds off until the result queue has fully drained
	task automatic test_drain_pause();
		send_random_message();
		byte_if.valid = 1'b0;
		wait_drained();
		send_framed(32'h5A5A_A5A5, 8'hA5, 8'h5A, '{8'h07, 8'h01, 8'h3C}, '{8'hC3});
	endtask

	// all-ones lengths: the message is left open when the run ends
	task automatic test_open_ended_message();
		send_message(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
			'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80});
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		byte_if.valid     = 1'b0;
		byte_if.data_byte = '0;
		idle_on           = 1'b1;
		mismatches        = 0;
		sent_bytes        = 0;
		rx_phase          = mhtd_pkg::PH_LEN;
		field_idx         = 0;
		len_acc           = '0;
		hlen_acc          = '0;
		id_acc            = '0;
		flags_acc         = '0;
		ctype_acc         = '0;
		area_left         = '0;
		opt_type_acc      = '0;
		opt_len_acc       = '0;
		value_left        = '0;
		msg_left          = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_minimal_messages();
		test_option_kinds();
		test_header_errors();
		test_option_errors();
		test_long_option();
		test_random_traffic();
		test_drain_pause();
		test_open_ended_message();

		byte_if.valid = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_items.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
